[rtl/core/nrts_pkg.sv]
package nrts_pkg;

   localparam int RING_BYTES_DEF = 2048;
   localparam int SOURCES_DEF    = 32;
   localparam int NAME_CHARS_DEF = 8;

   localparam logic [7:0] NEWLINE = 8'h0A;

   localparam logic [2:0] FUNC_EMIT  = 3'd0;
   localparam logic [2:0] FUNC_DUMP  = 3'd1;
   localparam logic [2:0] FUNC_TAIL  = 3'd2;
   localparam logic [2:0] FUNC_READ  = 3'd3;
   localparam logic [2:0] FUNC_CLEAR = 3'd4;
   localparam logic [2:0] FUNC_LIST  = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_SEARCH_WAIT,
      S_DECIDE,
      S_META_WAIT,
      S_ACT,
      S_BYTE_WAIT,
      S_SCAN_WAIT,
      S_SCAN,
      S_LIST_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic match;
      logic last;
   } cmp_status_type;

endpackage

[rtl/core/named_ring_trace_store.sv]
// Named ring trace store: up to SOURCES byte rings, each keyed by a packed name.
// One request transaction (req_valid/req_stall) yields exactly one response
// transaction (rsp_valid/rsp_stall). The block handles one request at a time;
// req_stall is high from acceptance until the response has been taken.
// Search: a name search walks the slot table through the shared compare unit,
// one slot at a time (name read, then compare). The next request is taken in
// the cycle after the response is taken. A read request adds a ring byte read.
// A tail request then scans the view backward one byte at a time through the
// ring RAM read port.
// A stalled response is held unchanged in the output register until taken;
// no new request is accepted meanwhile.
// Reset clears the source count and the controller; the name, head, fill and
// ring memories need no clearing because only registered slots and bytes
// inside a fill window are ever read.
module named_ring_trace_store #(
   parameter int RING_BYTES = nrts_pkg::RING_BYTES_DEF,
   parameter int SOURCES    = nrts_pkg::SOURCES_DEF,
   parameter int NAME_CHARS = nrts_pkg::NAME_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_name_key,
   input  logic        req_has_byte,
   input  logic [7:0]  req_data_in,
   input  logic [11:0] req_read_cap,
   input  logic [11:0] req_line_count,
   input  logic [10:0] req_view_offset,
   input  logic [4:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_byte_count,
   output logic [11:0] rsp_tail_skip,
   output logic [7:0]  rsp_data_out,
   output logic [63:0] rsp_name_out,
   output logic [5:0]  rsp_source_total
);

   localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int CW = $clog2(SOURCES + 1);
   localparam int RW = $clog2(RING_BYTES);
   localparam int FW = RW + 1;
   localparam int MW = SW + RW;
   localparam int SRC_DEPTH = 1 << SW;

   nrts_pkg::state_type state_ff, state_in;

   logic [2:0]  func_ff, func_in;
   logic [63:0] name_ff, name_in;
   logic        has_byte_ff, has_byte_in;
   logic [7:0]  data_ff, data_in_w;
   logic [FW-1:0] cap_ff, cap_in;
   logic [11:0] want_ff, want_in;
   logic [10:0] off_ff, off_in;
   logic [4:0]  sidx_ff, sidx_in;

   logic [CW-1:0] used_ff, used_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [RW-1:0] start_ff, start_in;
   logic [FW-1:0] view_ff, view_in;
   logic [FW-1:0] pos_ff, pos_in;
   logic [FW-1:0] scan_ff, scan_in;
   logic [11:0]   seen_ff, seen_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [11:0] count_ff, count_in;
   logic [11:0] skip_ff, skip_in;
   logic [7:0]  dout_ff, dout_in;
   logic [63:0] nout_ff, nout_in;

   logic [63:0] canon_name;
   nrts_canon #(.NAME_CHARS(NAME_CHARS)) u_canon (.key(req_name_key), .name(canon_name));

   logic          nm_we;
   logic [SW-1:0] nm_addr_w, nm_addr_r;
   logic [63:0]   nm_rd;
   logic          hd_we;
   logic [SW-1:0] hd_addr_w;
   logic [RW-1:0] hd_wdata, hd_rd;
   logic [FW-1:0] fl_wdata, fl_rd;
   logic          rb_we;
   logic [MW-1:0] rb_waddr, rb_raddr;
   logic [7:0]    rb_rd;

   nrts_ram #(.WIDTH(64), .DEPTH(SRC_DEPTH)) u_names (
      .clock, .wr_en(nm_we), .wr_addr(nm_addr_w), .wr_data(name_ff),
      .rd_addr(nm_addr_r), .rd_data(nm_rd));
   nrts_ram #(.WIDTH(RW), .DEPTH(SRC_DEPTH)) u_heads (
      .clock, .wr_en(hd_we), .wr_addr(hd_addr_w), .wr_data(hd_wdata),
      .rd_addr(nm_addr_r), .rd_data(hd_rd));
   nrts_ram #(.WIDTH(FW), .DEPTH(SRC_DEPTH)) u_fills (
      .clock, .wr_en(hd_we), .wr_addr(hd_addr_w), .wr_data(fl_wdata),
      .rd_addr(nm_addr_r), .rd_data(fl_rd));
   nrts_ram #(.WIDTH(8), .DEPTH(SRC_DEPTH * RING_BYTES)) u_ring (
      .clock, .wr_en(rb_we), .wr_addr(rb_waddr), .wr_data(data_ff),
      .rd_addr(rb_raddr), .rd_data(rb_rd));

   // Shared compare unit for the name search.
   nrts_pkg::cmp_status_type cmp;
   assign cmp.match = (nm_rd == name_ff);
   assign cmp.last  = ({{(CW-SW){1'b0}}, idx_ff} + CW'(1)) >= used_ff;

   logic [RW-1:0] rd_pos;
   logic [FW-1:0] pos_dec;
   assign pos_dec = pos_ff - FW'(1);
   assign rd_pos  = start_ff + pos_dec[RW-1:0];
   assign rb_raddr = {slot_ff, rd_pos};
   assign rb_waddr = {slot_ff, hd_rd};
   assign nm_addr_w = used_ff[SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nrts_pkg::S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;   name_ff <= name_in;   has_byte_ff <= has_byte_in;
      data_ff <= data_in_w; cap_ff <= cap_in;     want_ff <= want_in;
      off_ff <= off_in;     sidx_ff <= sidx_in;   idx_ff <= idx_in;
      found_ff <= found_in; slot_ff <= slot_in;   start_ff <= start_in;
      view_ff <= view_in;   pos_ff <= pos_in;     scan_ff <= scan_in;
      seen_ff <= seen_in;   status_ff <= status_in; count_ff <= count_in;
      skip_ff <= skip_in;   dout_ff <= dout_in;   nout_ff <= nout_in;
   end

   always_comb begin
      state_in = state_ff;
      func_in = func_ff; name_in = name_ff; has_byte_in = has_byte_ff;
      data_in_w = data_ff; cap_in = cap_ff; want_in = want_ff;
      off_in = off_ff; sidx_in = sidx_ff; used_in = used_ff;
      idx_in = idx_ff; found_in = found_ff; slot_in = slot_ff;
      start_in = start_ff; view_in = view_ff; pos_in = pos_ff;
      scan_in = scan_ff; seen_in = seen_ff;
      rsp_valid_in = rsp_valid_ff; status_in = status_ff; count_in = count_ff;
      skip_in = skip_ff; dout_in = dout_ff; nout_in = nout_ff;
      nm_we = 1'b0; hd_we = 1'b0; rb_we = 1'b0;
      nm_addr_r = idx_ff;
      hd_addr_w = slot_ff;
      hd_wdata = '0; fl_wdata = '0;
      req_stall = 1'b1;

      case (state_ff)
         nrts_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               func_in = req_func; name_in = canon_name; has_byte_in = req_has_byte;
               data_in_w = req_data_in;
               cap_in = (req_read_cap > 12'(RING_BYTES)) ? FW'(RING_BYTES)
                                                         : FW'(req_read_cap);
               want_in = req_line_count; off_in = req_view_offset;
               sidx_in = req_slot_index;
               status_in = nrts_pkg::ST_OK; count_in = '0; skip_in = '0;
               dout_in = '0; nout_in = '0;
               idx_in = '0; found_in = 1'b0;
               if (req_func == nrts_pkg::FUNC_LIST) begin
                  state_in = nrts_pkg::S_LIST_WAIT;
               end else if (req_func <= nrts_pkg::FUNC_CLEAR) begin
                  state_in = (used_ff == '0) ? nrts_pkg::S_DECIDE : nrts_pkg::S_SEARCH_WAIT;
               end else begin
                  state_in = nrts_pkg::S_DONE;
               end
            end
         end
         nrts_pkg::S_LIST_WAIT: begin
            nm_addr_r = sidx_ff[SW-1:0];
            if ({{(CW > 5 ? CW-5 : 0){1'b0}}, sidx_ff} >= (CW > 5 ? CW : 5)'(used_ff)
                || 32'(sidx_ff) >= 32'(SOURCES)) begin
               status_in = nrts_pkg::ST_RANGE;
               state_in = nrts_pkg::S_DONE;
            end else begin
               state_in = nrts_pkg::S_SEARCH;
            end
         end
         nrts_pkg::S_SEARCH_WAIT: begin
            state_in = nrts_pkg::S_SEARCH;
         end
         nrts_pkg::S_SEARCH: begin
            if (func_ff == nrts_pkg::FUNC_LIST) begin
               nout_in = nm_rd;
               count_in = 12'(fl_rd);
               state_in = nrts_pkg::S_DONE;
            end else if (cmp.match) begin
               found_in = 1'b1; slot_in = idx_ff;
               state_in = nrts_pkg::S_META_WAIT;
            end else if (cmp.last) begin
               state_in = nrts_pkg::S_DECIDE;
            end else begin
               idx_in = idx_ff + SW'(1);
               state_in = nrts_pkg::S_SEARCH_WAIT;
            end
         end
         nrts_pkg::S_DECIDE: begin
            if (func_ff != nrts_pkg::FUNC_EMIT) begin
               status_in = nrts_pkg::ST_NOT_FOUND;
               state_in = nrts_pkg::S_DONE;
            end else if (used_ff >= CW'(SOURCES)) begin
               status_in = nrts_pkg::ST_FULL;
               state_in = nrts_pkg::S_DONE;
            end else begin
               nm_we = 1'b1;
               slot_in = used_ff[SW-1:0];
               hd_we = 1'b1;
               hd_addr_w = used_ff[SW-1:0];
               used_in = used_ff + CW'(1);
               idx_in = used_ff[SW-1:0];
               state_in = nrts_pkg::S_META_WAIT;
            end
         end
         nrts_pkg::S_META_WAIT: begin
            nm_addr_r = slot_ff;
            state_in = nrts_pkg::S_ACT;
         end
         nrts_pkg::S_ACT: begin
            nm_addr_r = slot_ff;
            view_in = (fl_rd < cap_ff) ? fl_rd : cap_ff;
            start_in = hd_rd - fl_rd[RW-1:0];
            case (func_ff)
               nrts_pkg::FUNC_EMIT: begin
                  if (has_byte_ff) begin
                     rb_we = 1'b1;
                     hd_we = 1'b1;
                     hd_wdata = hd_rd + RW'(1);
                     fl_wdata = (fl_rd < FW'(RING_BYTES)) ? fl_rd + FW'(1) : fl_rd;
                     count_in = 12'(fl_wdata);
                  end else begin
                     count_in = 12'(fl_rd);
                  end
                  state_in = nrts_pkg::S_DONE;
               end
               nrts_pkg::FUNC_CLEAR: begin
                  hd_we = 1'b1;
                  state_in = nrts_pkg::S_DONE;
               end
               nrts_pkg::FUNC_DUMP: begin
                  count_in = 12'(view_in);
                  state_in = nrts_pkg::S_DONE;
               end
               nrts_pkg::FUNC_READ: begin
                  count_in = 12'(view_in);
                  if (FW'(off_ff) >= view_in) begin
                     status_in = nrts_pkg::ST_RANGE;
                     state_in = nrts_pkg::S_DONE;
                  end else begin
                     pos_in = FW'(off_ff) + FW'(1);
                     state_in = nrts_pkg::S_BYTE_WAIT;
                  end
               end
               default: begin
                  count_in = 12'(view_in);
                  if (want_ff == '0 || view_in == '0) begin
                     state_in = nrts_pkg::S_DONE;
                  end else begin
                     pos_in = view_in;
                     scan_in = view_in;
                     seen_in = '0;
                     state_in = nrts_pkg::S_SCAN_WAIT;
                  end
               end
            endcase
         end
         nrts_pkg::S_BYTE_WAIT: begin
            state_in = nrts_pkg::S_SCAN;
         end
         nrts_pkg::S_SCAN_WAIT: begin
            state_in = nrts_pkg::S_SCAN;
         end
         nrts_pkg::S_SCAN: begin
            if (func_ff == nrts_pkg::FUNC_READ) begin
               dout_in = rb_rd;
               state_in = nrts_pkg::S_DONE;
            end else if (pos_ff == view_ff && rb_rd == nrts_pkg::NEWLINE
                         && scan_ff == view_ff) begin
               scan_in = view_ff - FW'(1);
               pos_in = pos_dec;
               state_in = (pos_dec == '0) ? nrts_pkg::S_DONE : nrts_pkg::S_SCAN_WAIT;
            end else if (rb_rd == nrts_pkg::NEWLINE && pos_ff <= scan_ff
                         && seen_ff + 12'd1 == want_ff) begin
               count_in = 12'(view_ff - pos_ff);
               skip_in = 12'(pos_ff);
               state_in = nrts_pkg::S_DONE;
            end else begin
               if (rb_rd == nrts_pkg::NEWLINE && pos_ff <= scan_ff) begin
                  seen_in = seen_ff + 12'd1;
               end
               pos_in = pos_dec;
               state_in = (pos_dec == '0) ? nrts_pkg::S_DONE : nrts_pkg::S_SCAN_WAIT;
            end
         end
         nrts_pkg::S_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
            end else if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in = nrts_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = nrts_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_byte_count   = count_ff;
   assign rsp_tail_skip    = skip_ff;
   assign rsp_data_out     = dout_ff;
   assign rsp_name_out     = nout_ff;
   assign rsp_source_total = 6'(used_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(SOURCES)) else $error("source count above table size");
   a_rsp_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == nrts_pkg::S_DONE) else $error("response outside done");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      used_ff != $past(used_ff) |-> used_ff == $past(used_ff) + CW'(1))
      else $error("source count moved by more than one");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != nrts_pkg::S_IDLE |-> req_stall) else $error("ready while busy");

endmodule

[rtl/core/nrts_ram.sv]
module nrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/nrts_canon.sv]
module nrts_canon #(
   parameter int NAME_CHARS = nrts_pkg::NAME_CHARS_DEF
) (
   input  logic [63:0] key,
   output logic [63:0] name
);

   logic [8:0] alive;

   always_comb begin
      alive[0] = 1'b1;
      for (int i = 0; i < 8; i++) begin
         alive[i+1] = alive[i] && (key[8*i +: 8] != 8'h00) && (i < NAME_CHARS);
         name[8*i +: 8] = alive[i+1] ? key[8*i +: 8] : 8'h00;
      end
   end

endmodule
